// ===== rtl/core/ack_gated_command_sequencer_assert.svh =====
// Assertion macros shared by the command sequencer RTL.
`ifndef ACK_GATED_COMMAND_SEQUENCER_ASSERT_SVH
`define ACK_GATED_COMMAND_SEQUENCER_ASSERT_SVH
`ifndef SYNTHESIS
`define AGCS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("sequencer assertion failed");
`define AGCS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("sequencer assertion failed");
`else
`define AGCS_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define AGCS_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== rtl/core/agcs_pkg.sv =====
// Types, constants and the control store of the command sequencer.
package agcs_pkg;

    localparam int SEQ_DEPTH = 32;
    localparam int IDX_W     = $clog2(SEQ_DEPTH);
    localparam int PTR_W     = 6;
    localparam logic [PTR_W-1:0] DEPTH_P = PTR_W'(SEQ_DEPTH);
    localparam logic [31:0] RETRY_GAP_MS = 32'd250;
    localparam logic [3:0]  TRIES_MAX    = 4'hF;
    localparam logic [7:0]  LATCH_CODE_IDLE = 8'hFF;
    localparam logic [7:0]  REPLY_OK   = 8'd0;
    localparam logic [7:0]  REPLY_BUSY = 8'd1;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_START = 2'd1;
    localparam logic [1:0] ACT_ACK   = 2'd2;
    localparam logic [1:0] ACT_TICK  = 2'd3;

    // Input word, last field (step_index) in the lowest bits.
    typedef struct packed {
        logic [3:0]        pad;
        logic [31:0]       now_ms;
        logic signed [7:0] reply_code;
        logic [9:0]        reply_id;
        logic [5:0]        seq_length;
        logic [15:0]       post_delay_ms;
        logic              abort_on_fail;
        logic [3:0]        try_limit;
        logic [15:0]       timeout_ms;
        logic [9:0]        expect_id;
        logic [7:0]        command_code;
        logic [4:0]        step_index;
    } t_in_word;

    typedef struct packed {
        logic [4:0] pad;
        logic [5:0] current_step;
        logic       seq_failed;
        logic       seq_done;
        logic       awaiting_ack;
        logic       busy_res;
        logic [7:0] send_code;
        logic       send_valid;
    } t_out_word;

    typedef struct packed {
        logic [15:0] post_delay_ms;
        logic        abort_on_fail;
        logic [3:0]  try_limit;
        logic [15:0] timeout_ms;
        logic [9:0]  expect_id;
        logic [7:0]  command_code;
    } t_step;

    typedef enum logic [4:0] {
        U_FETCH, U_DISP_LOAD, U_DISP_START, U_DISP_ACK, U_TICK_RUN, U_TICK_END,
        U_TICK_DUE, U_TICK_WAIT, U_SEND, U_TICK_MATCH, U_ACK_EVAL, U_TICK_DL,
        U_FAIL, U_LOAD, U_START, U_ACK, U_EMIT
    } t_upc;

    typedef enum logic [3:0] {
        OP_NONE, OP_ACCEPT, OP_LOAD, OP_START, OP_ACK, OP_END, OP_SEND,
        OP_ACK_EVAL, OP_FAIL, OP_EMIT
    } t_uop;

    typedef enum logic [3:0] {
        C_ALWAYS, C_ITEM, C_IS_LOAD, C_IS_START, C_IS_ACK, C_IDLE, C_AT_END,
        C_NOT_DUE, C_WAITING, C_NO_MATCH, C_CODE_LOW, C_DL_REACHED, C_OUT_FREE
    } t_cond;

    typedef struct packed {
        t_uop  op;
        t_cond cond;
        t_upc  jt;
        t_upc  jf;
    } t_ctrl;

    // Control store: the condition picks the true or the false target.
    function automatic t_ctrl uc_rom(input t_upc pc);
        t_ctrl w;
        case (pc)
            U_FETCH:      w = '{OP_ACCEPT,   C_ITEM,       U_DISP_LOAD,  U_FETCH};
            U_DISP_LOAD:  w = '{OP_NONE,     C_IS_LOAD,    U_LOAD,       U_DISP_START};
            U_DISP_START: w = '{OP_NONE,     C_IS_START,   U_START,      U_DISP_ACK};
            U_DISP_ACK:   w = '{OP_NONE,     C_IS_ACK,     U_ACK,        U_TICK_RUN};
            U_TICK_RUN:   w = '{OP_NONE,     C_IDLE,       U_EMIT,       U_TICK_END};
            U_TICK_END:   w = '{OP_END,      C_AT_END,     U_EMIT,       U_TICK_DUE};
            U_TICK_DUE:   w = '{OP_NONE,     C_NOT_DUE,    U_EMIT,       U_TICK_WAIT};
            U_TICK_WAIT:  w = '{OP_NONE,     C_WAITING,    U_TICK_MATCH, U_SEND};
            U_SEND:       w = '{OP_SEND,     C_ALWAYS,     U_EMIT,       U_EMIT};
            U_TICK_MATCH: w = '{OP_NONE,     C_NO_MATCH,   U_TICK_DL,    U_ACK_EVAL};
            U_ACK_EVAL:   w = '{OP_ACK_EVAL, C_CODE_LOW,   U_EMIT,       U_FAIL};
            U_TICK_DL:    w = '{OP_NONE,     C_DL_REACHED, U_FAIL,       U_EMIT};
            U_FAIL:       w = '{OP_FAIL,     C_ALWAYS,     U_EMIT,       U_EMIT};
            U_LOAD:       w = '{OP_LOAD,     C_ALWAYS,     U_EMIT,       U_EMIT};
            U_START:      w = '{OP_START,    C_ALWAYS,     U_EMIT,       U_EMIT};
            U_ACK:        w = '{OP_ACK,      C_ALWAYS,     U_EMIT,       U_EMIT};
            U_EMIT:       w = '{OP_EMIT,     C_OUT_FREE,   U_FETCH,      U_EMIT};
            default:      w = '{OP_NONE,     C_ALWAYS,     U_FETCH,      U_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/ack_gated_command_sequencer.sv =====
// Microcoded command sequencer with acknowledge wait, retry, timeout and abort.
//
// Usage: each input word on the s_ channel carries one action in s_tuser (load a
// step entry, start the sequence, an acknowledge, a millisecond tick) and the
// fields in s_tdata. Every accepted word yields exactly one result word on the
// m_ channel with the command to send, if any, and the sequencer status.
// A small control store walks each word through the datapath. A tick changes nothing
// while idle, ends the sequence at the end of the table, waits when not yet due,
// issues a command, handles an ok or in-process reply or finds the deadline not yet
// reached, or retries or aborts on a failure reply or a timeout.
// The step table is a 32-entry memory whose registered read port follows the step
// pointer every cycle, so the entry is ready well before a tick examines it.
// One word is in flight at a time; the next is taken in the cycle after the result
// has been placed in the output register. If the receiver stalls, the result is held
// and a further result waits in the control store until the register frees. Reset is
// synchronous and clears all control state; the step table keeps its contents and
// must be loaded before a sequence is started.
`include "ack_gated_command_sequencer_assert.svh"

module ack_gated_command_sequencer (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // step_index, command_code, expect_id, timeout_ms, try_limit, abort_on_fail,
    // post_delay_ms, seq_length, reply_id, reply_code, now_ms, zero fill
    input  logic [119:0] s_tdata,
    // action
    input  logic [1:0]   s_tuser,
    output logic         m_tvalid,
    input  logic         m_tready,
    // send_valid, send_code, busy_res, awaiting_ack, seq_done, seq_failed,
    // current_step, zero fill
    output logic [23:0]  m_tdata
);

    agcs_pkg::t_upc    r_upc, n_upc;
    agcs_pkg::t_ctrl   ctrl;
    logic              cond_true;

    agcs_pkg::t_in_word r_in;
    logic [1:0]         r_action;

    agcs_pkg::t_step   r_table [agcs_pkg::SEQ_DEPTH];
    agcs_pkg::t_step   r_entry;

    logic                       r_running;
    logic [agcs_pkg::PTR_W-1:0] r_step_ptr;
    logic [agcs_pkg::PTR_W-1:0] r_step_count;
    logic [3:0]                 r_tries_used;
    logic                       r_waiting;
    logic                       r_failed;
    logic [31:0]                r_next_time;
    logic [31:0]                r_deadline;
    logic                       r_latch_valid;
    logic [9:0]                 r_latch_id;
    logic [7:0]                 r_latch_code;

    logic       r_send;
    logic [7:0] r_send_code;
    logic       r_done;

    logic                r_m_valid;
    agcs_pkg::t_out_word r_m_data;

    logic        out_free;
    logic        at_end;
    logic [31:0] due_diff;
    logic [31:0] dl_diff;
    logic        exhausted;
    logic [31:0] post_time;
    logic [31:0] tmo_time;

    assign out_free  = !r_m_valid || m_tready;
    assign at_end    = (r_step_ptr >= r_step_count) || (r_step_ptr >= agcs_pkg::DEPTH_P);
    assign due_diff  = r_in.now_ms - r_next_time;
    assign dl_diff   = r_in.now_ms - r_deadline;
    assign exhausted = r_tries_used >= r_entry.try_limit;
    assign post_time = r_in.now_ms + {16'd0, r_entry.post_delay_ms};
    assign tmo_time  = r_in.now_ms + {16'd0, r_entry.timeout_ms};

    assign ctrl = agcs_pkg::uc_rom(r_upc);

    always_comb begin
        case (ctrl.cond)
            agcs_pkg::C_ALWAYS:     cond_true = 1'b1;
            agcs_pkg::C_ITEM:       cond_true = s_tvalid;
            agcs_pkg::C_IS_LOAD:    cond_true = r_action == agcs_pkg::ACT_LOAD;
            agcs_pkg::C_IS_START:   cond_true = r_action == agcs_pkg::ACT_START;
            agcs_pkg::C_IS_ACK:     cond_true = r_action == agcs_pkg::ACT_ACK;
            agcs_pkg::C_IDLE:       cond_true = !r_running;
            agcs_pkg::C_AT_END:     cond_true = at_end;
            agcs_pkg::C_NOT_DUE:    cond_true = due_diff[31];
            agcs_pkg::C_WAITING:    cond_true = r_waiting;
            agcs_pkg::C_NO_MATCH:   cond_true = !(r_latch_valid &&
                                                  r_latch_id == r_entry.expect_id);
            agcs_pkg::C_CODE_LOW:   cond_true = (r_latch_code == agcs_pkg::REPLY_OK) ||
                                                (r_latch_code == agcs_pkg::REPLY_BUSY);
            agcs_pkg::C_DL_REACHED: cond_true = !dl_diff[31];
            agcs_pkg::C_OUT_FREE:   cond_true = out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    // Next step of the control program.
    always_comb begin
        n_upc = cond_true ? ctrl.jt : ctrl.jf;
    end

    // Control outputs decoded from the current word.
    always_comb begin
        s_tready = (ctrl.op == agcs_pkg::OP_ACCEPT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= agcs_pkg::U_FETCH;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Step table: one write port, one registered read port at the step pointer.
    always_ff @(posedge i_clk) begin
        if (ctrl.op == agcs_pkg::OP_LOAD &&
            {1'b0, r_in.step_index} < agcs_pkg::DEPTH_P) begin
            r_table[r_in.step_index[agcs_pkg::IDX_W-1:0]] <= '{
                post_delay_ms: r_in.post_delay_ms,
                abort_on_fail: r_in.abort_on_fail,
                try_limit:     r_in.try_limit,
                timeout_ms:    r_in.timeout_ms,
                expect_id:     r_in.expect_id,
                command_code:  r_in.command_code
            };
        end
        r_entry <= r_table[r_step_ptr[agcs_pkg::IDX_W-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (s_tvalid && s_tready) begin
            r_in <= agcs_pkg::t_in_word'(s_tdata);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_action      <= agcs_pkg::ACT_LOAD;
            r_running     <= 1'b0;
            r_step_ptr    <= '0;
            r_step_count  <= '0;
            r_tries_used  <= '0;
            r_waiting     <= 1'b0;
            r_failed      <= 1'b0;
            r_next_time   <= '0;
            r_deadline    <= '0;
            r_latch_valid <= 1'b0;
            r_latch_id    <= '0;
            r_latch_code  <= agcs_pkg::LATCH_CODE_IDLE;
            r_send        <= 1'b0;
            r_send_code   <= '0;
            r_done        <= 1'b0;
        end else begin
            case (ctrl.op)
                agcs_pkg::OP_ACCEPT: begin
                    if (s_tvalid) begin
                        r_action    <= s_tuser;
                        r_send      <= 1'b0;
                        r_send_code <= '0;
                        r_done      <= 1'b0;
                    end
                end
                agcs_pkg::OP_START: begin
                    r_step_count <= (r_in.seq_length > agcs_pkg::DEPTH_P) ?
                                    agcs_pkg::DEPTH_P : r_in.seq_length;
                    r_step_ptr   <= '0;
                    r_tries_used <= '0;
                    r_waiting    <= 1'b0;
                    r_failed     <= 1'b0;
                    r_next_time  <= '0;
                    r_running    <= 1'b1;
                end
                agcs_pkg::OP_ACK: begin
                    r_latch_id    <= r_in.reply_id;
                    r_latch_code  <= r_in.reply_code;
                    r_latch_valid <= 1'b1;
                end
                agcs_pkg::OP_END: begin
                    if (at_end) begin
                        r_running <= 1'b0;
                        r_done    <= 1'b1;
                    end
                end
                agcs_pkg::OP_SEND: begin
                    r_send      <= 1'b1;
                    r_send_code <= r_entry.command_code;
                    if (r_entry.expect_id == '0) begin
                        r_step_ptr   <= r_step_ptr + 1'b1;
                        r_tries_used <= '0;
                        r_next_time  <= post_time;
                    end else begin
                        if (r_tries_used < agcs_pkg::TRIES_MAX) begin
                            r_tries_used <= r_tries_used + 1'b1;
                        end
                        r_latch_valid <= 1'b0;
                        r_latch_code  <= agcs_pkg::LATCH_CODE_IDLE;
                        r_waiting     <= 1'b1;
                        r_deadline    <= tmo_time;
                    end
                end
                agcs_pkg::OP_ACK_EVAL: begin
                    if (r_latch_code == agcs_pkg::REPLY_BUSY) begin
                        r_latch_valid <= 1'b0;
                        r_deadline    <= tmo_time;
                    end else if (r_latch_code == agcs_pkg::REPLY_OK) begin
                        r_waiting    <= 1'b0;
                        r_step_ptr   <= r_step_ptr + 1'b1;
                        r_tries_used <= '0;
                        r_next_time  <= post_time;
                    end
                end
                agcs_pkg::OP_FAIL: begin
                    r_waiting <= 1'b0;
                    if (exhausted && r_entry.abort_on_fail) begin
                        r_failed  <= 1'b1;
                        r_running <= 1'b0;
                        r_done    <= 1'b1;
                    end else begin
                        if (exhausted) begin
                            r_step_ptr   <= r_step_ptr + 1'b1;
                            r_tries_used <= '0;
                        end
                        r_next_time <= r_in.now_ms + agcs_pkg::RETRY_GAP_MS;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Output register: loaded when the program reaches its emit step and the register is free.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (ctrl.op == agcs_pkg::OP_EMIT && out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctrl.op == agcs_pkg::OP_EMIT && out_free) begin
            r_m_data <= '{
                pad:          '0,
                current_step: r_step_ptr,
                seq_failed:   r_failed,
                seq_done:     r_done,
                awaiting_ack: r_waiting,
                busy_res:     r_running,
                send_code:    r_send_code,
                send_valid:   r_send
            };
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = r_m_data;

    `AGCS_ASSERT_IMP(a_wait_needs_run, i_clk, i_rst_n, r_waiting, r_running)
    `AGCS_ASSERT_IMP(a_ptr_in_range, i_clk, i_rst_n, r_running, r_step_ptr <= r_step_count)
    `AGCS_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, r_m_valid && r_m_data.seq_done,
                     !r_m_data.busy_res)
    `AGCS_ASSERT_NXT(a_accept_dispatch, i_clk, i_rst_n, s_tvalid && s_tready,
                     r_upc == agcs_pkg::U_DISP_LOAD)

endmodule

// ===== dv/tb_ack_gated_command_sequencer.sv =====
// Self-checking testbench of the command sequencer: a directed table, then random step traffic.
module tb_ack_gated_command_sequencer;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [1:0]  act;
        logic [4:0]  idx;
        logic [7:0]  cmd;
        logic [9:0]  wait_id;
        logic [15:0] tmo;
        logic [3:0]  tries;
        logic        abort_f;
        logic [15:0] post;
        logic [5:0]  len;
        logic [9:0]  rid;
        logic [7:0]  rcode;
        logic [31:0] now;
        bit          typed;
        agcs_pkg::t_out_word want;
    } t_dir_row;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    // step_index, command_code, expect_id, timeout_ms, try_limit, abort_on_fail,
    // post_delay_ms, seq_length, reply_id, reply_code, now_ms, zero fill
    logic [119:0] s_tdata = '0;
    // action
    logic [1:0]   s_tuser = agcs_pkg::ACT_TICK;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // send_valid, send_code, busy_res, awaiting_ack, seq_done, seq_failed,
    // current_step, zero fill
    logic [23:0]  m_tdata;

    // Shadow of the sequencer state, advanced once per accepted word.
    agcs_pkg::t_step steps [agcs_pkg::SEQ_DEPTH];
    logic        seq_busy = 1'b0;
    logic [5:0]  seq_ptr = '0;
    logic [5:0]  seq_len = '0;
    logic [3:0]  try_cnt = '0;
    logic        ack_wait = 1'b0;
    logic        seq_fail = 1'b0;
    logic [31:0] next_ms = '0;
    logic [31:0] deadline_ms = '0;
    logic        reply_seen = 1'b0;
    logic [9:0]  reply_id_q = '0;
    logic [7:0]  reply_code_q = agcs_pkg::LATCH_CODE_IDLE;

    agcs_pkg::t_out_word status_due [$];
    agcs_pkg::t_out_word seen_word;
    agcs_pkg::t_out_word due_word;
    t_dir_row    rows [27];
    logic [31:0] wall_ms = '0;
    int          err_cnt = 0;
    int          burst_left = 0;
    int          word_cnt = 0;
    int          ack_cnt = 0;
    int          cmd_cnt = 0;
    int          end_cnt = 0;
    int          abort_cnt = 0;
    bit          hold_long = 1'b0;

    ack_gated_command_sequencer dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 i_clk = ~i_clk;

    function automatic agcs_pkg::t_out_word status_word(bit sv, logic [7:0] c, bit busy,
                                                        bit aw, bit dn, bit fl,
                                                        logic [5:0] p);
        agcs_pkg::t_out_word s;
        s = '0;
        s.send_valid   = sv;
        s.send_code    = c;
        s.busy_res     = busy;
        s.awaiting_ack = aw;
        s.seq_done     = dn;
        s.seq_failed   = fl;
        s.current_step = p;
        return s;
    endfunction

    // A time counts as reached once the wrapped difference is non-negative.
    function automatic bit time_due(logic [31:0] now_v, logic [31:0] t);
        logic [31:0] d;
        d = now_v - t;
        return !d[31];
    endfunction

    function automatic bit give_up_or_retry(agcs_pkg::t_step e, logic [31:0] now_v);
        ack_wait = 1'b0;
        if (try_cnt >= e.try_limit) begin
            if (e.abort_on_fail) begin
                seq_fail = 1'b1;
                seq_busy = 1'b0;
                return 1'b1;
            end
            seq_ptr = seq_ptr + 6'd1;
            try_cnt = '0;
        end
        next_ms = now_v + agcs_pkg::RETRY_GAP_MS;
        return 1'b0;
    endfunction

    task automatic predict_status(input logic [1:0] act, input agcs_pkg::t_in_word w,
                                  output agcs_pkg::t_out_word r);
        agcs_pkg::t_step e;
        bit          send;
        logic [7:0]  cmd;
        bit          ended;
        logic [31:0] now_v;
        send  = 1'b0;
        cmd   = '0;
        ended = 1'b0;
        now_v = w.now_ms;
        case (act)
            agcs_pkg::ACT_LOAD: begin
                steps[w.step_index] = '{post_delay_ms: w.post_delay_ms,
                                        abort_on_fail: w.abort_on_fail,
                                        try_limit: w.try_limit, timeout_ms: w.timeout_ms,
                                        expect_id: w.expect_id, command_code: w.command_code};
            end
            agcs_pkg::ACT_START: begin
                seq_len  = (w.seq_length > agcs_pkg::DEPTH_P) ? agcs_pkg::DEPTH_P
                                                               : w.seq_length;
                seq_ptr  = '0;
                try_cnt  = '0;
                ack_wait = 1'b0;
                seq_fail = 1'b0;
                next_ms  = '0;
                seq_busy = 1'b1;
            end
            agcs_pkg::ACT_ACK: begin
                reply_id_q   = w.reply_id;
                reply_code_q = w.reply_code;
                reply_seen   = 1'b1;
            end
            default: begin
                if (seq_busy) begin
                    if (seq_ptr >= seq_len) begin
                        seq_busy = 1'b0;
                        ended    = 1'b1;
                    end else if (time_due(now_v, next_ms)) begin
                        e = steps[seq_ptr[4:0]];
                        if (!ack_wait) begin
                            send = 1'b1;
                            cmd  = e.command_code;
                            if (try_cnt != agcs_pkg::TRIES_MAX)
                                try_cnt = try_cnt + 4'd1;
                            if (e.expect_id == '0) begin
                                seq_ptr = seq_ptr + 6'd1;
                                try_cnt = '0;
                                next_ms = now_v + 32'(e.post_delay_ms);
                            end else begin
                                reply_seen   = 1'b0;
                                reply_code_q = agcs_pkg::LATCH_CODE_IDLE;
                                ack_wait     = 1'b1;
                                deadline_ms  = now_v + 32'(e.timeout_ms);
                            end
                        end else if (reply_seen && reply_id_q == e.expect_id) begin
                            if (reply_code_q == agcs_pkg::REPLY_BUSY) begin
                                reply_seen  = 1'b0;
                                deadline_ms = now_v + 32'(e.timeout_ms);
                            end else if (reply_code_q == agcs_pkg::REPLY_OK) begin
                                ack_wait = 1'b0;
                                seq_ptr  = seq_ptr + 6'd1;
                                try_cnt  = '0;
                                next_ms  = now_v + 32'(e.post_delay_ms);
                            end else begin
                                ended = give_up_or_retry(e, now_v);
                            end
                        end else if (time_due(now_v, deadline_ms)) begin
                            ended = give_up_or_retry(e, now_v);
                        end
                    end
                end
            end
        endcase
        r = status_word(send, cmd, seq_busy, ack_wait, ended, seq_fail, seq_ptr);
    endtask

    // Offers one word, records what it must produce, then maybe pauses the burst.
    task automatic send_word(input logic [1:0] act, input agcs_pkg::t_in_word w,
                             input bit typed, input agcs_pkg::t_out_word want,
                             input bit drain);
        agcs_pkg::t_out_word pred;
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= w;
        do @(posedge i_clk); while (!s_tready);
        predict_status(act, w, pred);
        status_due.push_back(typed ? want : pred);
        word_cnt++;
        if (act == agcs_pkg::ACT_ACK)
            ack_cnt++;
        burst_left--;
        if (drain || burst_left <= 0) begin
            s_tvalid <= 1'b0;
            while (drain && status_due.size() != 0)
                @(posedge i_clk);
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                      : $urandom_range(1, 16);
        end
    endtask

    task automatic roll_entry(inout agcs_pkg::t_in_word w);
        int r;
        r = $urandom_range(0, 9);
        w.command_code = 8'($urandom);
        w.expect_id = (r < 3) ? 10'd0 : (r < 8) ? 10'($urandom_range(1, 7)) : 10'($urandom);
        r = $urandom_range(0, 9);
        w.timeout_ms = (r < 7) ? 16'($urandom_range(0, 300)) :
                       (r < 9) ? 16'($urandom) : 16'hFFFF;
        w.try_limit = ($urandom_range(0, 2) != 0) ? 4'($urandom_range(1, 3)) : 4'($urandom);
        w.abort_on_fail = 1'($urandom);
        w.post_delay_ms = ($urandom_range(0, 2) != 0) ? 16'($urandom_range(0, 100))
                                                       : 16'($urandom);
    endtask

    function automatic void check_field(string name, int unsigned exp_v, int unsigned act_v);
        if (exp_v != act_v) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
            err_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            seen_word = m_tdata;
            if (status_due.size() == 0) begin
                $display("%0t: unexpected result word, expected none, actual %h",
                         $time, m_tdata);
                err_cnt++;
            end else begin
                due_word = status_due.pop_front();
                check_field("send_valid", due_word.send_valid, seen_word.send_valid);
                check_field("send_code", due_word.send_code, seen_word.send_code);
                check_field("busy_res", due_word.busy_res, seen_word.busy_res);
                check_field("awaiting_ack", due_word.awaiting_ack, seen_word.awaiting_ack);
                check_field("seq_done", due_word.seq_done, seen_word.seq_done);
                check_field("seq_failed", due_word.seq_failed, seen_word.seq_failed);
                check_field("current_step", due_word.current_step, seen_word.current_step);
                check_field("zero fill", 0, seen_word.pad);
            end
            if (seen_word.send_valid)
                cmd_cnt++;
            if (seen_word.seq_done) begin
                end_cnt++;
                if (seen_word.seq_failed)
                    abort_cnt++;
            end
        end
    end

    // Receiver: phases of free flow, random stalls and a sparse pattern, plus one long hold.
    initial begin : rx_side
        int  mode;
        int  span;
        int  k;
        bit  held;
        held = 1'b0;
        while (!i_rst_n)
            @(posedge i_clk);
        forever begin
            if (hold_long && !held) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (400) @(posedge i_clk);
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(10, 80);
            for (k = 0; k < span; k++) begin
                case (mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    2:       m_tready <= (k % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 4) != 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("Run stopped by the watchdog at %0t", $time);
        $display("Verification failed");
        $finish;
    end

    initial begin : stim
        logic [127:0] noise;
        agcs_pkg::t_in_word w;
        logic [1:0]   act;
        int           r;
        int           rand_items;

        // act, idx, cmd, wait_id, tmo, tries, abort, post, len, rid, rcode, now, typed, want
        rows[0]  = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     1, status_word(0, 0, 0, 0, 0, 0, 0)};
        rows[1]  = '{agcs_pkg::ACT_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 5, 1, 0,
                     1, status_word(0, 0, 0, 0, 0, 0, 0)};
        rows[2]  = '{agcs_pkg::ACT_LOAD, 0, 8'hFF, 0, 0, 1, 0, 0, 0, 0, 0, 0,
                     1, status_word(0, 0, 0, 0, 0, 0, 0)};
        rows[3]  = '{agcs_pkg::ACT_LOAD, 1, 8'h5A, 10'h3FF, 16'hFFFF, 15, 0, 16'hFFFF,
                     0, 0, 0, 0,
                     1, status_word(0, 0, 0, 0, 0, 0, 0)};
        // A try limit of zero behaves as one; this step aborts on its first failure.
        rows[4]  = '{agcs_pkg::ACT_LOAD, 2, 8'h11, 1, 0, 0, 1, 0, 0, 0, 0, 0,
                     1, status_word(0, 0, 0, 0, 0, 0, 0)};
        rows[5]  = '{agcs_pkg::ACT_LOAD, 3, 8'h00, 2, 10, 2, 0, 5, 0, 0, 0, 0,
                     1, status_word(0, 0, 0, 0, 0, 0, 0)};
        rows[6]  = '{agcs_pkg::ACT_START, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     1, status_word(0, 0, 1, 0, 0, 0, 0)};
        rows[7]  = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 5,
                     1, status_word(0, 0, 0, 0, 1, 0, 0)};
        rows[8]  = '{agcs_pkg::ACT_START, 0, 0, 0, 0, 0, 0, 0, 4, 0, 0, 0,
                     1, status_word(0, 0, 1, 0, 0, 0, 0)};
        // With the top bit of the time set, the first step is not yet due.
        rows[9]  = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 32'h8000_0000,
                     0, '0};
        rows[10] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
                     1, status_word(1, 8'hFF, 1, 0, 0, 0, 1)};
        rows[11] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1, 0, '0};
        rows[12] = '{agcs_pkg::ACT_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 10'h3FF, 1, 0, 0, '0};
        rows[13] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 100, 0, '0};
        rows[14] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65635, 0, '0};
        rows[15] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65885, 0, '0};
        rows[16] = '{agcs_pkg::ACT_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 10'h3FF, 0, 0, 0, '0};
        rows[17] = '{agcs_pkg::ACT_LOAD, 3, 8'h33, 2, 10, 2, 0, 5, 0, 0, 0, 0, 0, '0};
        rows[18] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 65900, 0, '0};
        rows[19] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 131435, 0, '0};
        rows[20] = '{agcs_pkg::ACT_ACK, 0, 0, 0, 0, 0, 0, 0, 0, 1, 8'h80, 0, 0, '0};
        rows[21] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 131435,
                     1, status_word(0, 0, 0, 0, 1, 1, 2)};
        rows[22] = '{agcs_pkg::ACT_START, 0, 0, 0, 0, 0, 0, 0, 4, 0, 0, 0,
                     1, status_word(0, 0, 1, 0, 0, 0, 0)};
        rows[23] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 7,
                     1, status_word(1, 8'hFF, 1, 0, 0, 0, 1)};
        rows[24] = '{agcs_pkg::ACT_START, 0, 0, 0, 0, 0, 0, 0, 1, 0, 0, 0,
                     1, status_word(0, 0, 1, 0, 0, 0, 0)};
        rows[25] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 8,
                     1, status_word(1, 8'hFF, 1, 0, 0, 0, 1)};
        rows[26] = '{agcs_pkg::ACT_TICK, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9,
                     1, status_word(0, 0, 0, 0, 1, 0, 1)};

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            w = '0;
            w.step_index    = rows[i].idx;
            w.command_code  = rows[i].cmd;
            w.expect_id     = rows[i].wait_id;
            w.timeout_ms    = rows[i].tmo;
            w.try_limit     = rows[i].tries;
            w.abort_on_fail = rows[i].abort_f;
            w.post_delay_ms = rows[i].post;
            w.seq_length    = rows[i].len;
            w.reply_id      = rows[i].rid;
            w.reply_code    = rows[i].rcode;
            w.now_ms        = rows[i].now;
            // The sender holds off here until every result of the table is back.
            send_word(rows[i].act, w, rows[i].typed, rows[i].want, i == 26);
        end

        // Fill the whole table so that any sequence length reads written entries only.
        for (int i = 0; i < agcs_pkg::SEQ_DEPTH; i++) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            w = noise[119:0];
            w.pad = '0;
            w.step_index = 5'(i);
            roll_entry(w);
            send_word(agcs_pkg::ACT_LOAD, w, 1'b0, '0, 1'b0);
        end

        hold_long  = 1'b1;
        rand_items = 0;
        while (rand_items < 1000) begin
            noise = {$urandom, $urandom, $urandom, $urandom};
            w = noise[119:0];
            w.pad = '0;
            r = $urandom_range(0, 99);
            if (!seq_busy)
                act = (r < 45) ? agcs_pkg::ACT_START : (r < 65) ? agcs_pkg::ACT_LOAD :
                      (r < 80) ? agcs_pkg::ACT_ACK : agcs_pkg::ACT_TICK;
            else
                act = (r < 8) ? agcs_pkg::ACT_LOAD : (r < 11) ? agcs_pkg::ACT_START :
                      (r < 36) ? agcs_pkg::ACT_ACK : agcs_pkg::ACT_TICK;
            case (act)
                agcs_pkg::ACT_LOAD: roll_entry(w);
                agcs_pkg::ACT_START: begin
                    r = $urandom_range(0, 99);
                    w.seq_length = (r < 50) ? 6'($urandom_range(1, 6)) :
                                   (r < 65) ? 6'($urandom_range(7, 32)) :
                                   (r < 75) ? 6'd0 : (r < 85) ? 6'd32 :
                                   6'($urandom_range(33, 63));
                end
                agcs_pkg::ACT_ACK: begin
                    // Mostly the awaited acknowledge; the rest stays as noise.
                    if (ack_wait && $urandom_range(0, 3) != 0) begin
                        w.reply_id = steps[seq_ptr[4:0]].expect_id;
                        r = $urandom_range(0, 99);
                        w.reply_code = (r < 35) ? agcs_pkg::REPLY_OK :
                                       (r < 60) ? agcs_pkg::REPLY_BUSY : 8'($urandom);
                    end
                end
                default: begin
                    r = $urandom_range(0, 99);
                    if (r < 40)
                        wall_ms = wall_ms + 32'($urandom_range(0, 50));
                    else if (r < 75)
                        wall_ms = (ack_wait ? deadline_ms : next_ms) - 32'd1
                                  + 32'($urandom_range(0, 2));
                    else if (r < 95)
                        wall_ms = wall_ms + 32'($urandom_range(0, 400));
                    else
                        wall_ms = $urandom;
                    w.now_ms = wall_ms;
                end
            endcase
            // A tick while idle changes nothing and is not counted.
            if (act != agcs_pkg::ACT_TICK || seq_busy)
                rand_items++;
            send_word(act, w, 1'b0, '0, rand_items == 1000);
        end

        repeat (40) @(posedge i_clk);
        if (status_due.size() != 0) begin
            $display("%0t: %0d results missing, expected more, actual none",
                     $time, status_due.size());
            err_cnt++;
        end
        $display("Run covered %0d words with %0d acknowledges: %0d commands issued,",
                 word_cnt, ack_cnt, cmd_cnt);
        $display("%0d sequences ended, %0d of them by abort; %0d mismatches.",
                 end_cnt, abort_cnt, err_cnt);
        if (err_cnt == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
